// ===== design/tdmh_pkg.sv =====
package tdmh_pkg;

	localparam int CAPACITY_DEF  = 32;
	localparam int TIME_BITS_DEF = 48;
	localparam int SLOTS         = 32;
	localparam logic [15:0] MIN_LEAD_RESET = 16'd100;

	localparam logic [1:0] FN_ADD    = 2'd0;
	localparam logic [1:0] FN_EXPIRE = 2'd1;
	localparam logic [1:0] FN_CANCEL = 2'd2;
	localparam logic [1:0] FN_NOP    = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REFUSE = 2'd1;
	localparam logic [1:0] ST_NOREG  = 2'd2;

	localparam logic KIND_FIRED  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [47:0] now_us;
		logic [4:0]  timer_id;
		logic [31:0] interval_us;
		logic        repeat_flag;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  fired_id;
		logic [1:0]  status;
		logic        top_changed;
		logic        deadline_valid;
		logic [47:0] next_deadline;
		logic        last;
	} out_t;

endpackage

// ===== design/tdmh_id_chain.sv =====
module tdmh_id_chain #(
	parameter int DEPTH = tdmh_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [4:0] push_id,
	input  logic       shift,
	output logic [4:0] head,
	output logic       empty
);
	import tdmh_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [4:0]    cell_q [DEPTH];
	logic [CW-1:0] cnt_q;

	// Fill level: pushes land at the tail, a shift drops the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (shift) begin
			cnt_q <= cnt_q - CW'(1);
		end else if (push) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Each cell takes its upper neighbor on a shift or the new id when it is the tail.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		always_ff @(posedge clk) begin
			if (shift) begin
				cell_q[k] <= (k == DEPTH - 1) ? 5'd0 : cell_q[(k + 1) % DEPTH];
			end else if (push && cnt_q == CW'(k)) begin
				cell_q[k] <= push_id;
			end
		end
	end

	assign head  = cell_q[0];
	assign empty = (cnt_q == '0);
endmodule

// ===== design/timer_deadline_min_heap.sv =====
// Timer queue kept as a binary min-heap ordered by expiry time.
// An item is presented on cmd with start; it is taken at a clock edge where start is
// high and busy is low. busy stays high until the item's status result is driven on
// result; a new item may be taken at the edge that ends the status cycle.
// Results appear on result for one cycle each, marked by result_valid; the receiver
// cannot stall them. An expire item first gives one fired result per expired timer
// that was not cancelled, in pop order; every item ends with one status result
// (last set) that carries the next deadline when the heap is not empty.
// Steps to the status result: cancel, unused codes and a refused add go straight to
// it. An add first sifts the new entry up, one heap level per step. An expire pops
// each expired timer and, when two or more entries remain, sifts the moved entry
// down; then per expired timer it rearms a repeating, uncancelled one by a sift-up
// or frees its slot. A single sift unit works one heap level per cycle; one item is
// in work at a time.
// min_lead_us is written on the cfg channel, which is ready only while no item is in
// work. Reset empties the heap, frees all slots and sets min_lead_us to 100.
module timer_deadline_min_heap #(
	parameter int CAPACITY  = tdmh_pkg::CAPACITY_DEF,
	parameter int TIME_BITS = tdmh_pkg::TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tdmh_pkg::in_t  cmd,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data,
	output logic           result_valid,
	output tdmh_pkg::out_t result
);
	import tdmh_pkg::*;

	localparam int TB = TIME_BITS;
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_UP     = 6'b000010,
		S_POPCHK = 6'b000100,
		S_DOWN   = 6'b001000,
		S_REARM  = 6'b010000,
		S_STAT   = 6'b100000
	} state_t;

	function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [31:0] b);
		logic [TB:0] s;
		s = {1'b0, a} + (TB + 1)'(b);
		return s[TB] ? {TB{1'b1}} : s[TB-1:0];
	endfunction

	state_t         state_q;
	logic [15:0]    min_lead_q;
	logic [1:0]     func_q;
	logic [TB-1:0]  now_q;
	logic [1:0]     st_q;
	logic           tc_q;
	logic [TB-1:0]  e_exp_q;
	logic [4:0]     e_id_q;
	logic [IW-1:0]  i_q;
	logic [CW-1:0]  cnt_q;
	logic           out_valid_q;
	out_t           out_q;

	logic [TB-1:0]  h_exp [CAPACITY];
	logic [4:0]     h_id  [CAPACITY];
	logic [31:0]    ivl_q [SLOTS];
	logic           fq_q [SLOTS];
	logic           fc_q [SLOTS];
	logic           fr_q [SLOTS];

	logic [63:0]    now64;
	logic [TB-1:0]  now_in;
	logic [IW-1:0]  p_idx, last_idx, pick;
	logic [IW:0]    c_w, r_w;
	logic           up_move, c_in, r_in, down_move, pop_ok, rearm;
	logic [4:0]     head;
	logic           chain_empty, chain_push, chain_shift;
	logic           hwe;
	logic [IW-1:0]  hwa;
	logic [TB-1:0]  hw_exp;
	logic [4:0]     hw_id;
	logic [TB-1:0]  floor_t, nd_t;
	logic [63:0]    nd64;

	assign now64  = {16'd0, cmd.now_us};
	assign now_in = now64[TB-1:0];

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// Sift-up and sift-down compare terms for the current heap position.
	assign p_idx     = (i_q - IW'(1)) >> 1;
	assign up_move   = (i_q != '0) && (e_exp_q < h_exp[p_idx]);
	assign c_w       = {i_q, 1'b1};
	assign r_w       = c_w + (IW + 1)'(1);
	assign c_in      = c_w < (IW + 1)'(cnt_q);
	assign r_in      = r_w < (IW + 1)'(cnt_q);
	assign pick      = (r_in && h_exp[r_w[IW-1:0]] < h_exp[c_w[IW-1:0]]) ?
	                   r_w[IW-1:0] : c_w[IW-1:0];
	assign down_move = c_in && (h_exp[pick] < e_exp_q);
	assign last_idx  = IW'(cnt_q - CW'(1));
	assign pop_ok    = (cnt_q != '0) && (h_exp[0] <= now_q);
	assign rearm     = fr_q[head] && !fc_q[head] && (cnt_q < CW'(CAPACITY));

	assign chain_push  = (state_q == S_POPCHK) && pop_ok;
	assign chain_shift = (state_q == S_REARM) && !chain_empty;

	tdmh_id_chain #(.DEPTH(CAPACITY)) u_popped (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (chain_push),
		.push_id (h_id[0]),
		.shift   (chain_shift),
		.head    (head),
		.empty   (chain_empty)
	);

	// Heap write port: one entry per cycle.
	always_comb begin
		hwe    = 1'b0;
		hwa    = i_q;
		hw_exp = e_exp_q;
		hw_id  = e_id_q;
		case (state_q)
			S_UP: begin
				hwe = 1'b1;
				if (up_move) begin
					hw_exp = h_exp[p_idx];
					hw_id  = h_id[p_idx];
				end
			end
			S_POPCHK: begin
				if (pop_ok && cnt_q <= CW'(2)) begin
					hwe    = 1'b1;
					hwa    = '0;
					hw_exp = h_exp[last_idx];
					hw_id  = h_id[last_idx];
				end
			end
			S_DOWN: begin
				hwe = 1'b1;
				if (down_move) begin
					hw_exp = h_exp[pick];
					hw_id  = h_id[pick];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hwe) begin
			h_exp[hwa] <= hw_exp;
			h_id[hwa]  <= hw_id;
		end
	end

	// Interval store, written by an accepted add.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && cmd.func == FN_ADD && !fq_q[cmd.timer_id]
		    && cnt_q != CW'(CAPACITY)) begin
			ivl_q[cmd.timer_id] <= cmd.interval_us;
		end
	end

	// Status deadline, never earlier than now plus the minimum lead.
	assign floor_t = sat_add(now_q, 32'(min_lead_q));
	assign nd_t    = (h_exp[0] < floor_t) ? floor_t : h_exp[0];
	assign nd64    = 64'(nd_t);

	// Sequencer, slot flags and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_lead_q  <= MIN_LEAD_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < SLOTS; k++) begin
				fq_q[k] <= 1'b0;
				fc_q[k] <= 1'b0;
				fr_q[k] <= 1'b0;
			end
		end else begin
			out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				min_lead_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q <= cmd.func;
						now_q  <= now_in;
						st_q   <= ST_OK;
						tc_q   <= 1'b0;
						state_q <= S_STAT;
						case (cmd.func)
							FN_ADD: begin
								if (fq_q[cmd.timer_id] || cnt_q == CW'(CAPACITY)) begin
									st_q <= ST_REFUSE;
								end else begin
									fq_q[cmd.timer_id] <= 1'b1;
									fc_q[cmd.timer_id] <= 1'b0;
									fr_q[cmd.timer_id] <= cmd.repeat_flag;
									e_exp_q <= sat_add(now_in, cmd.interval_us);
									e_id_q  <= cmd.timer_id;
									i_q     <= IW'(cnt_q);
									cnt_q   <= cnt_q + CW'(1);
									state_q <= S_UP;
								end
							end
							FN_CANCEL: begin
								if (fq_q[cmd.timer_id] && !fc_q[cmd.timer_id]) begin
									fc_q[cmd.timer_id] <= 1'b1;
								end else begin
									st_q <= ST_NOREG;
								end
							end
							FN_EXPIRE: state_q <= S_POPCHK;
							default: ;
						endcase
					end
				end
				S_UP: begin
					if (up_move) begin
						i_q <= p_idx;
					end else begin
						if (func_q == FN_ADD) begin
							tc_q    <= (i_q == '0);
							state_q <= S_STAT;
						end else begin
							state_q <= S_REARM;
						end
					end
				end
				S_POPCHK: begin
					if (pop_ok) begin
						if (!fc_q[h_id[0]]) begin
							out_valid_q          <= 1'b1;
							out_q.kind           <= KIND_FIRED;
							out_q.fired_id       <= h_id[0];
							out_q.status         <= ST_OK;
							out_q.top_changed    <= 1'b0;
							out_q.deadline_valid <= 1'b0;
							out_q.next_deadline  <= 48'd0;
							out_q.last           <= 1'b0;
						end
						cnt_q   <= cnt_q - CW'(1);
						e_exp_q <= h_exp[last_idx];
						e_id_q  <= h_id[last_idx];
						i_q     <= '0;
						if (cnt_q > CW'(2)) begin
							state_q <= S_DOWN;
						end
					end else begin
						state_q <= S_REARM;
					end
				end
				S_DOWN: begin
					if (down_move) begin
						i_q <= pick;
					end else begin
						state_q <= S_POPCHK;
					end
				end
				S_REARM: begin
					if (chain_empty) begin
						state_q <= S_STAT;
					end else if (rearm) begin
						e_exp_q <= sat_add(now_q, ivl_q[head]);
						e_id_q  <= head;
						i_q     <= IW'(cnt_q);
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_UP;
					end else begin
						fq_q[head] <= 1'b0;
						fc_q[head] <= 1'b0;
						fr_q[head] <= 1'b0;
					end
				end
				S_STAT: begin
					out_valid_q          <= 1'b1;
					out_q.kind           <= KIND_STATUS;
					out_q.fired_id       <= 5'd0;
					out_q.status         <= st_q;
					out_q.top_changed    <= tc_q;
					out_q.deadline_valid <= (cnt_q != '0);
					out_q.next_deadline  <= (cnt_q != '0) ? nd64[47:0] : 48'd0;
					out_q.last           <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;
endmodule
